// ===== src/bthalloc_pkg.sv =====
package bthalloc_pkg;

  localparam int unsigned HEAP_BYTES_DEF  = 65536;
  localparam int unsigned CHUNK_BYTES_DEF = 4096;
  localparam int unsigned TAG_W           = 32;
  localparam int unsigned MIN_BLOCK       = 16;
  localparam int unsigned HEAP_BASE       = 8;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  typedef struct packed {
    logic        status;
    logic [15:0] addr;
  } res_t;

endpackage

// ===== src/bth_ram.sv =====
module bth_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bth_core.sv =====
module bth_core
  import bthalloc_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  fit_mode,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [16:0] req,
  input  logic [15:0] tgt,
  output logic        idle,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int unsigned OFF_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned W     = (OFF_W > 18 ? OFF_W : 18) + 1;
  localparam int unsigned WORDS = HEAP_BYTES / 4;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam logic [W-1:0] HEAPW = W'(HEAP_BYTES);
  localparam logic [W-1:0] CHK   = W'(((CHUNK_BYTES + 7) / 8) * 8);
  localparam logic [W-1:0] BASE  = W'(HEAP_BASE);
  localparam logic [W-1:0] MINB  = W'(MIN_BLOCK);

  typedef enum logic [20:0] {
    ST_IDLE = 21'd1 << 0,
    ST_INI  = 21'd1 << 1,
    ST_GRW  = 21'd1 << 2,
    ST_GRW1 = 21'd1 << 3,
    ST_GRW2 = 21'd1 << 4,
    ST_MG0  = 21'd1 << 5,
    ST_MG1  = 21'd1 << 6,
    ST_MG2  = 21'd1 << 7,
    ST_MG3  = 21'd1 << 8,
    ST_MG4  = 21'd1 << 9,
    ST_SR0  = 21'd1 << 10,
    ST_SR1  = 21'd1 << 11,
    ST_TK0  = 21'd1 << 12,
    ST_TK1  = 21'd1 << 13,
    ST_TK2  = 21'd1 << 14,
    ST_TK3  = 21'd1 << 15,
    ST_TK4  = 21'd1 << 16,
    ST_FR0  = 21'd1 << 17,
    ST_FR1  = 21'd1 << 18,
    ST_FR2  = 21'd1 << 19,
    ST_DONE = 21'd1 << 20
  } state_t;

  state_t       state_r, state_nxt;
  logic [1:0]   kind_r, kind_nxt;
  logic [W-1:0] bp_r, bp_nxt, size_r, size_nxt, psz_r, psz_nxt;
  logic [W-1:0] need_r, need_nxt, gsz_r, gsz_nxt, brk_r, brk_nxt, cur_r, cur_nxt;
  logic [W-1:0] best_r, best_nxt, bsz_r, bsz_nxt;
  logic         pa_r, pa_nxt, pass_r, pass_nxt, split_r, split_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [15:0]  tgt_r, tgt_nxt, addr_r, addr_nxt;
  logic         status_r, status_nxt;

  logic [TAG_W-1:0] rdata, wval32;
  logic [W-1:0]     rd_s, nb, roff, woff, wval;
  logic             rd_a, we;

  bth_ram #(.DW(TAG_W), .DEPTH(WORDS)) u_tags (
    .clk   (clk),
    .we    (we),
    .waddr (woff[AW+1:2]),
    .wdata (wval32),
    .raddr (roff[AW+1:2]),
    .rdata (rdata)
  );

  assign rd_s   = W'(rdata[W-1:0]) & ~W'(7);
  assign rd_a   = rdata[0];
  assign nb     = bp_r + rd_s;
  assign wval32 = TAG_W'(wval);

  always_comb begin
    if (state_r == ST_MG1) begin
      roff = bp_r - W'(8);
    end else if (state_r == ST_MG2) begin
      roff = bp_r + size_r - W'(4);
    end else begin
      roff = bp_r - W'(4);
    end
  end

  always_comb begin
    logic [W-1:0] reqw, nd, nbp, nsz, bn, bsn, ts;
    logic         fit, endw, mnext, mfirst, to_miss, to_endpass, to_post;
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    bp_nxt     = bp_r;
    size_nxt   = size_r;
    psz_nxt    = psz_r;
    pa_nxt     = pa_r;
    need_nxt   = need_r;
    gsz_nxt    = gsz_r;
    brk_nxt    = brk_r;
    cur_nxt    = cur_r;
    best_nxt   = best_r;
    bsz_nxt    = bsz_r;
    pass_nxt   = pass_r;
    split_nxt  = split_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    we         = 1'b0;
    woff       = bp_r - W'(4);
    wval       = '0;
    reqw       = W'(req);
    nd         = (reqw <= W'(8)) ? MINB : ((reqw + W'(15)) & ~W'(7));
    nbp        = bp_r;
    nsz        = size_r;
    bn         = best_r;
    bsn        = bsz_r;
    ts         = split_r ? need_r : size_r;
    fit        = !rd_a && (need_r <= rd_s);
    endw       = (rd_s < W'(8)) || (bp_r >= brk_r) || (nb >= brk_r);
    mnext      = (fit_mode == FIT_NEXT);
    mfirst     = (fit_mode == FIT_FIRST);
    to_miss    = 1'b0;
    to_endpass = 1'b0;
    to_post    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt   = kind;
          status_nxt = 1'b1;
          addr_nxt   = '0;
          state_nxt  = ST_DONE;
          if (kind == KIND_INIT) begin
            brk_nxt   = W'(16);
            cur_nxt   = '0;
            cnt_nxt   = '0;
            gsz_nxt   = CHK;
            state_nxt = ST_INI;
          end else if (kind == KIND_ALLOC) begin
            need_nxt = nd;
            gsz_nxt  = (nd > CHK) ? nd : CHK;
            best_nxt = '0;
            pass_nxt = 1'b0;
            if (brk_r != '0 && req != '0) begin
              state_nxt = ST_SR0;
              if (mnext) begin
                bp_nxt  = (cur_r == '0) ? BASE : cur_r;
                cur_nxt = (cur_r == '0) ? BASE : cur_r;
              end else begin
                bp_nxt = BASE;
              end
            end
          end else if (kind == KIND_FREE) begin
            tgt_nxt = tgt;
            bp_nxt  = BASE;
            if (brk_r != '0) begin
              state_nxt = ST_FR0;
            end
          end
        end
      end
      ST_INI: begin
        we      = 1'b1;
        woff    = W'(cnt_r) << 2;
        wval    = (cnt_r == 2'd0) ? '0 : (cnt_r == 2'd3) ? W'(1) : W'(9);
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_GRW;
        end
      end
      ST_GRW: begin
        if (gsz_r > HEAPW || brk_r > HEAPW - gsz_r) begin
          status_nxt = 1'b1;
          addr_nxt   = '0;
          state_nxt  = ST_DONE;
        end else begin
          we        = 1'b1;
          woff      = brk_r - W'(4);
          wval      = gsz_r;
          bp_nxt    = brk_r;
          brk_nxt   = brk_r + gsz_r;
          state_nxt = ST_GRW1;
        end
      end
      ST_GRW1: begin
        we        = 1'b1;
        woff      = bp_r + gsz_r - W'(8);
        wval      = gsz_r;
        state_nxt = ST_GRW2;
      end
      ST_GRW2: begin
        we        = 1'b1;
        woff      = bp_r + gsz_r - W'(4);
        wval      = W'(1);
        state_nxt = ST_MG0;
      end
      ST_MG0: state_nxt = ST_MG1;
      ST_MG1: begin
        size_nxt  = rd_s;
        state_nxt = ST_MG2;
      end
      ST_MG2: begin
        pa_nxt    = rd_a;
        psz_nxt   = rd_s;
        state_nxt = ST_MG3;
      end
      ST_MG3: begin
        if (pa_r && rd_a) begin
          cur_nxt = bp_r;
          to_post = 1'b1;
        end else begin
          nsz       = size_r + (rd_a ? '0 : rd_s) + (pa_r ? '0 : psz_r);
          nbp       = pa_r ? bp_r : bp_r - psz_r;
          we        = 1'b1;
          woff      = nbp - W'(4);
          wval      = nsz;
          bp_nxt    = nbp;
          size_nxt  = nsz;
          cur_nxt   = nbp;
          state_nxt = ST_MG4;
        end
      end
      ST_MG4: begin
        we      = 1'b1;
        woff    = bp_r + size_r - W'(8);
        wval    = size_r;
        to_post = 1'b1;
      end
      ST_SR0: begin
        if (mnext && bp_r >= (pass_r ? cur_r : brk_r)) begin
          to_endpass = 1'b1;
        end else begin
          state_nxt = ST_SR1;
        end
      end
      ST_SR1: begin
        if (mfirst) begin
          if (fit) begin
            state_nxt = ST_TK0;
          end else if (endw) begin
            to_miss = 1'b1;
          end else begin
            bp_nxt    = nb;
            state_nxt = ST_SR0;
          end
        end else if (mnext) begin
          if (fit) begin
            cur_nxt   = bp_r;
            state_nxt = ST_TK0;
          end else if (endw) begin
            to_endpass = 1'b1;
          end else begin
            bp_nxt    = nb;
            state_nxt = ST_SR0;
          end
        end else begin
          if (fit && (best_r == '0 || rd_s < bsz_r)) begin
            bn  = bp_r;
            bsn = rd_s;
          end
          best_nxt = bn;
          bsz_nxt  = bsn;
          if (endw) begin
            if (bn != '0) begin
              bp_nxt    = bn;
              state_nxt = ST_TK0;
            end else begin
              to_miss = 1'b1;
            end
          end else begin
            bp_nxt    = nb;
            state_nxt = ST_SR0;
          end
        end
      end
      ST_TK0: state_nxt = ST_TK1;
      ST_TK1: begin
        size_nxt  = rd_s;
        split_nxt = (rd_s - need_r) >= MINB;
        we        = 1'b1;
        woff      = bp_r - W'(4);
        wval      = (((rd_s - need_r) >= MINB) ? need_r : rd_s) | W'(1);
        state_nxt = ST_TK2;
      end
      ST_TK2: begin
        we   = 1'b1;
        woff = bp_r + ts - W'(8);
        wval = ts | W'(1);
        if (split_r) begin
          state_nxt = ST_TK3;
        end else begin
          status_nxt = 1'b0;
          addr_nxt   = bp_r[15:0];
          state_nxt  = ST_DONE;
        end
      end
      ST_TK3: begin
        we        = 1'b1;
        woff      = bp_r + need_r - W'(4);
        wval      = size_r - need_r;
        state_nxt = ST_TK4;
      end
      ST_TK4: begin
        we         = 1'b1;
        woff       = bp_r + size_r - W'(8);
        wval       = size_r - need_r;
        status_nxt = 1'b0;
        addr_nxt   = bp_r[15:0];
        state_nxt  = ST_DONE;
      end
      ST_FR0: state_nxt = ST_FR1;
      ST_FR1: begin
        state_nxt = ST_DONE;
        if (rd_s == '0) begin
          state_nxt = ST_DONE;
        end else if (bp_r == W'(tgt_r)) begin
          if (bp_r != BASE && rd_a) begin
            we        = 1'b1;
            woff      = bp_r - W'(4);
            wval      = rd_s;
            size_nxt  = rd_s;
            state_nxt = ST_FR2;
          end
        end else if (bp_r > W'(tgt_r) || endw) begin
          state_nxt = ST_DONE;
        end else begin
          bp_nxt    = nb;
          state_nxt = ST_FR0;
        end
      end
      ST_FR2: begin
        we        = 1'b1;
        woff      = bp_r + size_r - W'(8);
        wval      = size_r;
        state_nxt = ST_MG0;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (to_endpass) begin
      if (!pass_r) begin
        pass_nxt  = 1'b1;
        bp_nxt    = BASE;
        state_nxt = ST_SR0;
      end else begin
        to_miss = 1'b1;
      end
    end
    if (to_miss) begin
      state_nxt = ST_GRW;
    end
    if (to_post) begin
      if (kind_r == KIND_ALLOC) begin
        state_nxt = ST_TK0;
      end else begin
        status_nxt = 1'b0;
        addr_nxt   = '0;
        state_nxt  = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      brk_r   <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      brk_r   <= brk_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    bp_r     <= bp_nxt;
    size_r   <= size_nxt;
    psz_r    <= psz_nxt;
    pa_r     <= pa_nxt;
    need_r   <= need_nxt;
    gsz_r    <= gsz_nxt;
    best_r   <= best_nxt;
    bsz_r    <= bsz_nxt;
    pass_r   <= pass_nxt;
    split_r  <= split_nxt;
    cnt_r    <= cnt_nxt;
    tgt_r    <= tgt_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
  end

  assign idle       = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res.status = status_r;
  assign res.addr   = addr_r;

`ifndef NO_ASSERTIONS
  a_brk_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r[2:0] == 3'd0) else $error("heap break misaligned");
  a_walk_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SR1 || state_r == ST_FR1) |-> bp_r[2:0] == 3'd0)
    else $error("walk pointer misaligned");
  a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && kind_r == KIND_ALLOC && !status_r) |-> addr_r != '0)
    else $error("successful allocate without address");
  a_brk_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(brk_r) |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_GRW))
    else $error("heap break moved outside growth");
`endif

endmodule

// ===== src/boundary_tag_heap_allocator_unit.sv =====
// Channel  Direction  Fields (low bit first)
// in_      slave      tuser: kind; tdata: request_size[16:0], block_addr[32:17]
// out_     master     tuser: status; tdata: addr[15:0]
// cfg_     write      wr_data: fit_mode
// Init: writes the start tags, then grows and merges; free: walks the blocks, then frees and merges.
// Allocate: walks the blocks (next fit up to two passes), grows and merges the heap on a
// miss, then takes the block, with or without a split.
// Every step is one tag memory read (registered) or write; the result then passes to the
// output register.
// Reset clears heap break, cursor and fit_mode (best fit); tag memory is not cleared.
// A finished result sits in the output register while the next transfer is taken.
module boundary_tag_heap_allocator_unit
  import bthalloc_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [39:0] in_tdata,   // request_size, block_addr, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // status
  output logic [15:0] out_tdata,  // addr
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // fit_mode
);

  logic [1:0] fit_mode_r;
  logic       out_valid_r;
  res_t       out_r;
  logic       core_idle, res_valid, res_ready;
  res_t       res;

  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  bth_core #(.HEAP_BYTES(HEAP_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fit_mode  (fit_mode_r),
    .start     (in_tvalid && core_idle),
    .kind      (in_tuser),
    .req       (in_tdata[16:0]),
    .tgt       (in_tdata[32:17]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r  <= FIT_BEST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = out_r.addr;

endmodule

// ===== dv/boundary_tag_heap_allocator_unit_test.sv =====
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_unit_test;
  import bthalloc_pkg::*;

  localparam int unsigned HEAP_SZ  = 65536;
  localparam int unsigned CHUNK_SZ = 4096;
  localparam int unsigned WORDS    = HEAP_SZ / 4;
  localparam int unsigned CYCLE_LIMIT = 50000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] FIT_SPARE   = 2'd3;

  // Allocator prediction with its own heap image and the expected responses.
  class heap_scoreboard;
    bit [31:0] tags [WORDS];
    bit [31:0] brk;
    bit [31:0] cursor;
    bit [1:0]  policy;
    res_t      pending [$];
    int        errors;
    bit [15:0] live [$];

    function new();
      brk = 0; cursor = 0; policy = FIT_BEST; errors = 0;
    endfunction

    function bit [31:0] rdw(bit [31:0] off);
      return (off >> 2) < WORDS ? tags[off >> 2] : 32'd0;
    endfunction

    function void wrw(bit [31:0] off, bit [31:0] v);
      if ((off >> 2) < WORDS) tags[off >> 2] = v;
    endfunction

    function bit [31:0] blen(bit [31:0] bp);
      return rdw(bp - 4) & ~32'd7;
    endfunction

    function bit used(bit [31:0] bp);
      return 1'(rdw(bp - 4) & 32'd1);
    endfunction

    function void mark(bit [31:0] bp, bit [31:0] sz, bit a);
      wrw(bp - 4, sz | 32'(a));
      wrw(bp + sz - 8, sz | 32'(a));
    endfunction

    function bit [31:0] coalesce(bit [31:0] bp);
      bit [31:0] sz, nxt;
      bit pa, na;
      sz = blen(bp);
      pa = 1'(rdw(bp - 8) & 32'd1);
      nxt = bp + sz;
      na = 1'(rdw(nxt - 4) & 32'd1);
      if (pa && !na) begin
        sz += blen(nxt);
        mark(bp, sz, 0);
      end else if (!pa && na) begin
        bp -= rdw(bp - 8) & ~32'd7;
        sz += blen(bp);
        mark(bp, sz, 0);
      end else if (!pa && !na) begin
        sz += blen(nxt);
        bp -= rdw(bp - 8) & ~32'd7;
        sz += blen(bp);
        mark(bp, sz, 0);
      end
      cursor = bp;
      return bp;
    endfunction

    function bit [31:0] extend(bit [31:0] bytes);
      bit [31:0] bp;
      bp = brk;
      if (bytes > HEAP_SZ || bp > HEAP_SZ - bytes) return 0;
      brk = bp + bytes;
      mark(bp, bytes, 0);
      wrw(bp + bytes - 4, 1);
      return coalesce(bp);
    endfunction

    function bit [31:0] walk(bit [31:0] bp);
      bit [31:0] s;
      s = blen(bp);
      if (s < 8 || bp >= brk) return 0;
      bp += s;
      if (bp >= brk || blen(bp) == 0) return 0;
      return bp;
    endfunction

    function bit ok(bit [31:0] bp, bit [31:0] need);
      return !used(bp) && need <= blen(bp);
    endfunction

    function bit [31:0] find(bit [31:0] need);
      bit [31:0] bp, best;
      best = 0;
      if (policy == FIT_FIRST) begin
        for (bp = HEAP_BASE; bp != 0; bp = walk(bp)) if (ok(bp, need)) return bp;
        return 0;
      end
      if (policy == FIT_NEXT) begin
        if (cursor == 0) cursor = HEAP_BASE;
        for (bp = cursor; bp != 0 && bp < brk; bp = walk(bp))
          if (ok(bp, need)) begin
            cursor = bp;
            return bp;
          end
        for (bp = HEAP_BASE; bp != 0 && bp < cursor; bp = walk(bp))
          if (ok(bp, need)) begin
            cursor = bp;
            return bp;
          end
        return 0;
      end
      for (bp = HEAP_BASE; bp != 0; bp = walk(bp))
        if (ok(bp, need) && (best == 0 || blen(bp) < blen(best))) best = bp;
      return best;
    endfunction

    function bit [31:0] grow_len(bit [31:0] need);
      bit [31:0] c;
      c = (CHUNK_SZ + 7) & ~32'd7;
      return need > c ? need : c;
    endfunction

    function void note_input(bit [1:0] kind, bit [16:0] req, bit [15:0] target);
      res_t r;
      bit [31:0] need, bp, have;
      r.status = 1; r.addr = 0;
      if (kind == KIND_INIT) begin
        brk = 16; cursor = 0;
        wrw(0, 0); wrw(4, 9); wrw(8, 9); wrw(12, 1);
        if (extend(grow_len(0)) != 0) r.status = 0;
        live.delete();
      end else if (kind == KIND_ALLOC) begin
        if (brk != 0 && req != 0) begin
          need = req <= 8 ? MIN_BLOCK : 8 * ((req + 15) / 8);
          bp = find(need);
          if (bp == 0) bp = extend(grow_len(need));
          if (bp != 0) begin
            have = blen(bp);
            if (have - need >= MIN_BLOCK) begin
              mark(bp, need, 1);
              mark(bp + need, have - need, 0);
            end else mark(bp, have, 1);
            r.status = 0; r.addr = bp[15:0];
            live.push_back(bp[15:0]);
          end
        end
      end else if (kind == KIND_FREE) begin
        if (brk != 0)
          for (bp = HEAP_BASE; bp != 0; bp = walk(bp)) begin
            if (bp == target) begin
              if (bp != HEAP_BASE && used(bp)) begin
                mark(bp, blen(bp), 0);
                void'(coalesce(bp));
                r.status = 0;
              end
              break;
            end
            if (bp > target) break;
          end
      end
      pending.push_back(r);
    endfunction

    function void check_result(bit status, bit [15:0] addr);
      res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d addr=%0d", status, addr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, status);
        errors++;
      end
      if (addr !== e.addr) begin
        $error("addr: expected %0d actual %0d", e.addr, addr);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [1:0]  in_tuser = 0;
  logic [39:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic        out_tuser;
  logic [15:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_wr_data = 0;

  heap_scoreboard sb = new();
  int cycles = 0;
  bit rx_quiet = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  boundary_tag_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 4);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** boundary_tag_heap_allocator_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // Receiver stalls: random, with quiet stretches of always-ready.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (rx_quiet) out_tready <= 1;
      else begin
        g = gap_len();
        out_tready <= (g == 0);
      end
    end
  end

  // Valid stays up after a transfer until the next send or drain lowers it.
  task automatic send(input bit [1:0] kind, input bit [16:0] req, input bit [15:0] target);
    int g;
    g = rx_quiet ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, target, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(kind, req, target);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_policy(input bit [1:0] p);
    drain();
    cfg_wr_en   <= 1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.policy = p;
  endtask

  function automatic bit [16:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 17'($urandom_range(0, 8));
      1: return 17'($urandom_range(4000, 12000));
      2: return 17'(32'h10000 - $urandom_range(0, 16));
      default: return 17'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic random_run(input int n);
    bit [15:0] a;
    int idx, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) send(KIND_INIT, 17'($urandom), 16'($urandom));
      else if (r < 55) send(KIND_ALLOC, rand_size(), 16'($urandom));
      else if (r < 90 && sb.live.size() != 0) begin
        idx = $urandom_range(0, sb.live.size() - 1);
        a = sb.live[idx];
        sb.live.delete(idx);
        send(KIND_FREE, 17'($urandom), a);
      end else if (r < 95) send(KIND_FREE, 17'($urandom), 16'($urandom));
      else send(KIND_UNUSED, 17'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: before init, then init and the edge cases.
    send(KIND_ALLOC, 17'd16, 16'd0);
    send(KIND_FREE, 17'd0, 16'd8);
    send(KIND_INIT, 17'h1FFFF, 16'hFFFF);
    send(KIND_ALLOC, 17'd0, 16'd0);
    send(KIND_ALLOC, 17'd1, 16'd0);
    send(KIND_ALLOC, 17'd8, 16'd0);
    send(KIND_ALLOC, 17'd9, 16'd0);
    send(KIND_ALLOC, 17'd5000, 16'd0);
    send(KIND_ALLOC, 17'h10000, 16'd0);
    send(KIND_ALLOC, 17'h1FFFF, 16'd0);
    send(KIND_FREE, 17'd0, 16'd8);
    send(KIND_FREE, 17'd0, 16'd13);
    send(KIND_FREE, 17'd0, 16'hFFFF);
    send(KIND_FREE, 17'd0, 16'd32);
    send(KIND_FREE, 17'd0, 16'd32);
    send(KIND_FREE, 17'd0, 16'd24);
    send(KIND_UNUSED, 17'h1FFFF, 16'hFFFF);
    send(KIND_INIT, 17'd0, 16'd0);
    for (int i = 0; i < 16; i++) send(KIND_ALLOC, 17'd4000, 16'd0);
    send(KIND_INIT, 17'd0, 16'd0);
    sb.live.delete();

    set_policy(FIT_FIRST);
    random_run(170);
    set_policy(FIT_NEXT);
    rx_quiet = 1;
    random_run(170);
    rx_quiet = 0;
    set_policy(FIT_SPARE);
    random_run(90);
    set_policy(FIT_BEST);
    random_run(170);
    set_policy(FIT_NEXT);
    random_run(80);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** boundary_tag_heap_allocator_unit: PASSED **");
    else
      $display("** boundary_tag_heap_allocator_unit: FAILED **");
    $finish;
  end

endmodule
